// ----- hdl/cszp_pkg.sv -----
// Shared types and constants for the compact-size record field parser.
package cszp_pkg;

   // Command queue between the parse front and the beat back end
   localparam int QUEUE_DEPTH = 4;
   localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
   localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

   // Size prefix escape codes
   localparam logic [7:0] SIZE_ESC_16 = 8'd253;
   localparam logic [7:0] SIZE_ESC_32 = 8'd254;
   localparam logic [3:0] SIZE_BYTES_16 = 4'd2;
   localparam logic [3:0] SIZE_BYTES_32 = 4'd4;
   localparam logic [3:0] SIZE_BYTES_64 = 4'd8;

   // Trailer holds a method word and an iteration word
   localparam logic [3:0] TRAILER_BYTES = 4'd8;

   // Register reset values
   localparam logic [31:0] METHOD_RESET  = 32'd0;
   localparam logic [7:0]  MIN_KEY_RESET = 8'd32;

   // Register indexes (byte address bit 2)
   localparam logic REG_ACCEPTED_METHOD = 1'b0;
   localparam logic REG_MIN_KEY_BYTES   = 1'b1;

   typedef enum logic [1:0] {
      KIND_KEY     = 2'd0,
      KIND_SALT    = 2'd1,
      KIND_SUMMARY = 2'd2
   } kind_type;

   typedef enum logic [2:0] {
      ST_OK        = 3'd0,
      ST_TRUNCATED = 3'd1,
      ST_EMPTY     = 3'd2,
      ST_METHOD    = 3'd3,
      ST_SHORT_KEY = 3'd4
   } status_type;

   typedef enum logic [6:0] {
      PH_KEY_PFX   = 7'b0000001,
      PH_KEY_EXT   = 7'b0000010,
      PH_KEY_DATA  = 7'b0000100,
      PH_SALT_PFX  = 7'b0001000,
      PH_SALT_EXT  = 7'b0010000,
      PH_SALT_DATA = 7'b0100000,
      PH_TRAILER   = 7'b1000000
   } phase_type;

   typedef struct packed {
      logic [31:0] accepted_method;
      logic [7:0]  min_key_bytes;
   } cfg_type;

   // One queued command: an optional field beat and an optional summary
   typedef struct packed {
      logic        has_beat;
      kind_type    beat_kind;
      logic [7:0]  beat_byte;
      logic        beat_window;
      logic        has_sum;
      status_type  status;
      logic [31:0] method;
      logic [31:0] iterations;
      logic [63:0] key_length;
      logic [63:0] salt_length;
   } cmd_type;

   typedef struct packed {
      logic full;
      logic empty;
   } qstat_type;

endpackage

// ----- hdl/cszp_csr.sv -----
// Configuration registers behind the APB-style port.
module cszp_csr (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [2:0]            csr_paddr,
   input  logic [31:0]           csr_pwdata,
   output logic [31:0]           csr_prdata,
   output logic                  csr_pready,
   output cszp_pkg::cfg_type     cfg
);

   logic [31:0] method_ff;
   logic [7:0]  min_key_ff;
   logic        wr_en;

   assign csr_pready = 1'b1;
   assign wr_en      = csr_psel & csr_penable & csr_pwrite & csr_pready;

   // Register writes
   always_ff @(posedge clock) begin
      if (reset) begin
         method_ff  <= cszp_pkg::METHOD_RESET;
         min_key_ff <= cszp_pkg::MIN_KEY_RESET;
      end else if (wr_en) begin
         if (csr_paddr[2] == cszp_pkg::REG_ACCEPTED_METHOD) begin
            method_ff <= csr_pwdata;
         end else begin
            min_key_ff <= csr_pwdata[7:0];
         end
      end
   end

   // Read mux
   always_comb begin
      if (csr_paddr[2] == cszp_pkg::REG_MIN_KEY_BYTES) begin
         csr_prdata = {24'd0, min_key_ff};
      end else begin
         csr_prdata = method_ff;
      end
   end

   assign cfg.accepted_method = method_ff;
   assign cfg.min_key_bytes   = min_key_ff;

endmodule

// ----- hdl/cszp_front.sv -----
// Parse front: takes record bytes, tracks field sizes and builds queue commands.
module cszp_front (
   input  logic                  clock,
   input  logic                  reset,
   input  cszp_pkg::cfg_type     cfg,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  logic [7:0]            req_data_byte,
   input  logic                  req_last_byte,
   input  cszp_pkg::qstat_type   q_stat,
   output logic                  push,
   output cszp_pkg::cmd_type     push_cmd
);

   cszp_pkg::phase_type phase_ff, phase_in;
   logic [3:0]  prefix_left_ff, prefix_left_in;
   logic [2:0]  prefix_shift_ff, prefix_shift_in;
   logic [63:0] size_acc_ff, size_acc_in;
   logic [63:0] bytes_rem_ff, bytes_rem_in;
   logic [63:0] key_len_ff, key_len_in;
   logic [63:0] salt_size_ff, salt_size_in;
   logic [3:0]  trailer_count_ff, trailer_count_in;
   logic [63:0] trailer_words_ff, trailer_words_in;

   logic        accept;
   logic [63:0] ext_sum;
   logic [63:0] trailer_sum;
   logic [3:0]  ext_left_dec;
   logic [63:0] rem_dec;
   logic [3:0]  first_len;
   logic        size_done;
   logic        size_is_key;
   logic [63:0] size_val;
   logic        full_trailer;
   logic [31:0] sum_method;
   logic [31:0] sum_iter;
   cszp_pkg::cmd_type cmd;

   assign req_ready = ~q_stat.full;
   assign accept    = req_valid & req_ready;

   // Byte lane insertion for size bytes and trailer bytes
   always_comb begin
      for (int i = 0; i < 8; i++) begin
         ext_sum[i*8 +: 8] = (prefix_shift_ff == 3'(i)) ? req_data_byte
                                                        : size_acc_ff[i*8 +: 8];
         trailer_sum[i*8 +: 8] = (trailer_count_ff[2:0] == 3'(i)) ? req_data_byte
                                                                  : trailer_words_ff[i*8 +: 8];
      end
   end

   assign ext_left_dec = prefix_left_ff - 4'd1;
   assign rem_dec      = bytes_rem_ff - 64'd1;

   // Extra size bytes that follow an escape code
   always_comb begin
      if (req_data_byte == cszp_pkg::SIZE_ESC_16) begin
         first_len = cszp_pkg::SIZE_BYTES_16;
      end else if (req_data_byte == cszp_pkg::SIZE_ESC_32) begin
         first_len = cszp_pkg::SIZE_BYTES_32;
      end else begin
         first_len = cszp_pkg::SIZE_BYTES_64;
      end
   end

   // Next state and command for the byte on the input
   always_comb begin
      phase_in         = phase_ff;
      prefix_left_in   = prefix_left_ff;
      prefix_shift_in  = prefix_shift_ff;
      size_acc_in      = size_acc_ff;
      bytes_rem_in     = bytes_rem_ff;
      key_len_in       = key_len_ff;
      salt_size_in     = salt_size_ff;
      trailer_count_in = trailer_count_ff;
      trailer_words_in = trailer_words_ff;
      size_done        = 1'b0;
      size_is_key      = 1'b0;
      size_val         = '0;
      full_trailer     = 1'b0;
      sum_method       = '0;
      sum_iter         = '0;
      cmd              = '0;
      cmd.beat_kind    = cszp_pkg::KIND_KEY;
      cmd.status       = cszp_pkg::ST_OK;

      unique case (phase_ff)
         cszp_pkg::PH_KEY_PFX, cszp_pkg::PH_SALT_PFX: begin
            size_is_key = (phase_ff == cszp_pkg::PH_KEY_PFX);
            if (req_data_byte < cszp_pkg::SIZE_ESC_16) begin
               size_done = 1'b1;
               size_val  = 64'(req_data_byte);
            end else begin
               prefix_left_in  = first_len;
               prefix_shift_in = '0;
               size_acc_in     = '0;
               phase_in        = size_is_key ? cszp_pkg::PH_KEY_EXT : cszp_pkg::PH_SALT_EXT;
            end
         end
         cszp_pkg::PH_KEY_EXT, cszp_pkg::PH_SALT_EXT: begin
            size_is_key     = (phase_ff == cszp_pkg::PH_KEY_EXT);
            size_acc_in     = ext_sum;
            prefix_shift_in = prefix_shift_ff + 3'd1;
            prefix_left_in  = ext_left_dec;
            if (ext_left_dec == 4'd0) begin
               size_done = 1'b1;
               size_val  = ext_sum;
            end
         end
         cszp_pkg::PH_KEY_DATA: begin
            cmd.has_beat    = 1'b1;
            cmd.beat_kind   = cszp_pkg::KIND_KEY;
            cmd.beat_byte   = req_data_byte;
            cmd.beat_window = (bytes_rem_ff <= 64'(cfg.min_key_bytes));
            bytes_rem_in    = rem_dec;
            if (rem_dec == 64'd0) begin
               phase_in = cszp_pkg::PH_SALT_PFX;
            end
         end
         cszp_pkg::PH_SALT_DATA: begin
            cmd.has_beat  = 1'b1;
            cmd.beat_kind = cszp_pkg::KIND_SALT;
            cmd.beat_byte = req_data_byte;
            bytes_rem_in  = rem_dec;
            if (rem_dec == 64'd0) begin
               phase_in = cszp_pkg::PH_TRAILER;
            end
         end
         cszp_pkg::PH_TRAILER: begin
            if (trailer_count_ff < cszp_pkg::TRAILER_BYTES) begin
               trailer_words_in = trailer_sum;
               trailer_count_in = trailer_count_ff + 4'd1;
            end
         end
         default: begin
            phase_in = cszp_pkg::PH_KEY_PFX;
         end
      endcase

      // Field size complete: latch length and pick the next phase
      if (size_done) begin
         bytes_rem_in = size_val;
         if (size_is_key) begin
            key_len_in = size_val;
            phase_in   = (size_val != 64'd0) ? cszp_pkg::PH_KEY_DATA : cszp_pkg::PH_SALT_PFX;
         end else begin
            salt_size_in = size_val;
            phase_in     = (size_val != 64'd0) ? cszp_pkg::PH_SALT_DATA : cszp_pkg::PH_TRAILER;
         end
      end

      // End of record: build summary and rearm
      if (req_last_byte) begin
         full_trailer = (phase_in == cszp_pkg::PH_TRAILER) &&
                        (trailer_count_in >= cszp_pkg::TRAILER_BYTES);
         sum_method   = full_trailer ? trailer_words_in[31:0] : 32'd0;
         sum_iter     = full_trailer ? trailer_words_in[63:32] : 32'd0;
         cmd.has_sum     = 1'b1;
         cmd.method      = sum_method;
         cmd.iterations  = sum_iter;
         cmd.key_length  = key_len_in;
         cmd.salt_length = salt_size_in;
         priority if (phase_in != cszp_pkg::PH_TRAILER) begin
            cmd.status = cszp_pkg::ST_TRUNCATED;
         end else if ((key_len_in == 64'd0) || (salt_size_in == 64'd0)) begin
            cmd.status = cszp_pkg::ST_EMPTY;
         end else if (sum_method != cfg.accepted_method) begin
            cmd.status = cszp_pkg::ST_METHOD;
         end else if (key_len_in < 64'(cfg.min_key_bytes)) begin
            cmd.status = cszp_pkg::ST_SHORT_KEY;
         end else begin
            cmd.status = cszp_pkg::ST_OK;
         end
         phase_in         = cszp_pkg::PH_KEY_PFX;
         prefix_left_in   = '0;
         prefix_shift_in  = '0;
         size_acc_in      = '0;
         bytes_rem_in     = '0;
         key_len_in       = '0;
         salt_size_in     = '0;
         trailer_count_in = '0;
         trailer_words_in = '0;
      end
   end

   assign push     = accept & (cmd.has_beat | cmd.has_sum);
   assign push_cmd = cmd;

   // Parser state
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff         <= cszp_pkg::PH_KEY_PFX;
         prefix_left_ff   <= '0;
         prefix_shift_ff  <= '0;
         size_acc_ff      <= '0;
         bytes_rem_ff     <= '0;
         key_len_ff       <= '0;
         salt_size_ff     <= '0;
         trailer_count_ff <= '0;
         trailer_words_ff <= '0;
      end else if (accept) begin
         phase_ff         <= phase_in;
         prefix_left_ff   <= prefix_left_in;
         prefix_shift_ff  <= prefix_shift_in;
         size_acc_ff      <= size_acc_in;
         bytes_rem_ff     <= bytes_rem_in;
         key_len_ff       <= key_len_in;
         salt_size_ff     <= salt_size_in;
         trailer_count_ff <= trailer_count_in;
         trailer_words_ff <= trailer_words_in;
      end
   end

endmodule

// ----- hdl/cszp_queue.sv -----
// Short command queue between the parse front and the beat back end.
module cszp_queue (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  push,
   input  cszp_pkg::cmd_type     push_cmd,
   input  logic                  pop,
   output cszp_pkg::cmd_type     head_cmd,
   output cszp_pkg::qstat_type   q_stat
);

   cszp_pkg::cmd_type entries_ff [cszp_pkg::QUEUE_DEPTH];
   logic [cszp_pkg::QUEUE_PTR_W-1:0] wr_ptr_ff, rd_ptr_ff;
   logic [cszp_pkg::QUEUE_CNT_W-1:0] count_ff, count_in;

   assign q_stat.full  = (count_ff == cszp_pkg::QUEUE_CNT_W'(cszp_pkg::QUEUE_DEPTH));
   assign q_stat.empty = (count_ff == '0);
   assign head_cmd     = entries_ff[rd_ptr_ff];

   // Occupancy follows push and pop
   always_comb begin
      unique case ({push, pop})
         2'b10:   count_in = count_ff + cszp_pkg::QUEUE_CNT_W'(1);
         2'b01:   count_in = count_ff - cszp_pkg::QUEUE_CNT_W'(1);
         default: count_in = count_ff;
      endcase
   end

   // Pointers and count
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= wr_ptr_ff + cszp_pkg::QUEUE_PTR_W'(1);
         end
         if (pop) begin
            rd_ptr_ff <= rd_ptr_ff + cszp_pkg::QUEUE_PTR_W'(1);
         end
         count_ff <= count_in;
      end
   end

   // Entry storage
   always_ff @(posedge clock) begin
      if (push) begin
         entries_ff[wr_ptr_ff] <= push_cmd;
      end
   end

endmodule

// ----- hdl/cszp_back.sv -----
// Beat back end: expands each queued command into one or two result beats.
module cszp_back (
   input  logic                  clock,
   input  logic                  reset,
   input  cszp_pkg::cmd_type     head_cmd,
   input  cszp_pkg::qstat_type   q_stat,
   output logic                  pop,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output logic [1:0]            rsp_kind,
   output logic [7:0]            rsp_value_byte,
   output logic                  rsp_in_window,
   output logic [2:0]            rsp_status,
   output logic [31:0]           rsp_method,
   output logic [31:0]           rsp_iterations,
   output logic [63:0]           rsp_key_length,
   output logic [63:0]           rsp_salt_length
);

   logic second_ff, second_in;
   logic show_sum;
   logic beat_done;

   assign rsp_valid = ~q_stat.empty;
   assign beat_done = rsp_valid & rsp_ready;
   assign show_sum  = ~head_cmd.has_beat | second_ff;

   // Field beat first, then summary beat of the same command
   always_comb begin
      pop       = 1'b0;
      second_in = second_ff;
      if (beat_done) begin
         if (!show_sum && head_cmd.has_sum) begin
            second_in = 1'b1;
         end else begin
            pop       = 1'b1;
            second_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         second_ff <= 1'b0;
      end else begin
         second_ff <= second_in;
      end
   end

   // Beat payload select
   always_comb begin
      if (show_sum) begin
         rsp_kind        = cszp_pkg::KIND_SUMMARY;
         rsp_value_byte  = '0;
         rsp_in_window   = 1'b0;
         rsp_status      = head_cmd.status;
         rsp_method      = head_cmd.method;
         rsp_iterations  = head_cmd.iterations;
         rsp_key_length  = head_cmd.key_length;
         rsp_salt_length = head_cmd.salt_length;
      end else begin
         rsp_kind        = head_cmd.beat_kind;
         rsp_value_byte  = head_cmd.beat_byte;
         rsp_in_window   = head_cmd.beat_window;
         rsp_status      = cszp_pkg::ST_OK;
         rsp_method      = '0;
         rsp_iterations  = '0;
         rsp_key_length  = '0;
         rsp_salt_length = '0;
      end
   end

endmodule

// ----- hdl/compact_size_record_field_parser.sv -----
// Top level of the compact-size record field parser.
//
// Usage: feed one record byte per beat on req_* (valid/ready), with
// req_last_byte high on the final byte. Key and salt payload bytes come
// back on rsp_* as kind key / kind salt beats; key beats carry
// rsp_in_window for the final min_key_bytes bytes of the key. The final
// byte of a record also yields a summary beat with status, method and
// iteration words and both declared lengths; a final byte that is a
// payload byte gives its field beat first, then the summary.
// Throughput: one byte per cycle while the command queue has room; a byte
// that yields two beats holds the output for both. Each beat is registered
// in a four-entry command queue between the parse front and the output
// side before it appears on rsp_*, so req_ready only drops when that
// queue is full; a stalled receiver fills it, then back-pressures req_*.
// Reset: synchronous, clears the parser to the start of a record, empties
// the queue and loads accepted_method = 0 and min_key_bytes = 32.
// Registers (csr_*): 0x0 accepted_method, 0x4 min_key_bytes; write only
// while no record is in flight.
module compact_size_record_field_parser (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [2:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [7:0]  req_data_byte,
   input  logic        req_last_byte,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [1:0]  rsp_kind,
   output logic [7:0]  rsp_value_byte,
   output logic        rsp_in_window,
   output logic [2:0]  rsp_status,
   output logic [31:0] rsp_method,
   output logic [31:0] rsp_iterations,
   output logic [63:0] rsp_key_length,
   output logic [63:0] rsp_salt_length
);

   cszp_pkg::cfg_type   cfg;
   cszp_pkg::qstat_type q_stat;
   cszp_pkg::cmd_type   push_cmd;
   cszp_pkg::cmd_type   head_cmd;
   logic                push;
   logic                pop;

   cszp_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   cszp_front u_front (
      .clock         (clock),
      .reset         (reset),
      .cfg           (cfg),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_data_byte (req_data_byte),
      .req_last_byte (req_last_byte),
      .q_stat        (q_stat),
      .push          (push),
      .push_cmd      (push_cmd)
   );

   cszp_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_cmd (push_cmd),
      .pop      (pop),
      .head_cmd (head_cmd),
      .q_stat   (q_stat)
   );

   cszp_back u_back (
      .clock           (clock),
      .reset           (reset),
      .head_cmd        (head_cmd),
      .q_stat          (q_stat),
      .pop             (pop),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_kind        (rsp_kind),
      .rsp_value_byte  (rsp_value_byte),
      .rsp_in_window   (rsp_in_window),
      .rsp_status      (rsp_status),
      .rsp_method      (rsp_method),
      .rsp_iterations  (rsp_iterations),
      .rsp_key_length  (rsp_key_length),
      .rsp_salt_length (rsp_salt_length)
   );

   // Queue occupancy flags never both set
   assert property (@(posedge clock) disable iff (reset)
      !(q_stat.full && q_stat.empty))
      else $error("queue reports full and empty together");

   // Output side is quiet right after reset
   assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result beat present after reset");

   // Field beats carry no summary content
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_kind != cszp_pkg::KIND_SUMMARY) |->
         (rsp_status == cszp_pkg::ST_OK && rsp_key_length == 64'd0 &&
          rsp_salt_length == 64'd0 && rsp_method == 32'd0))
      else $error("field beat carries summary data");

   // Window mark only on key beats
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_in_window) |-> (rsp_kind == cszp_pkg::KIND_KEY))
      else $error("window mark on a non-key beat");

endmodule
